// ----- rtl/bmpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP decoder package
// Shared widths, codes, result types and small helper functions.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int MAX_DIM   = 2048;
    localparam int BYTE_W    = 8;
    localparam int ORIGIN_W  = 11;
    localparam int COORD_W   = 12;
    localparam int CNT_W     = 12;
    localparam int CMP_W     = CNT_W + 1;
    localparam int COLOR_W   = 16;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = ORIGIN_W;

    localparam logic [COLOR_W-1:0] KEY_COLOR = 16'hF81F;
    localparam logic [BYTE_W-1:0]  SIG_B     = 8'h42;
    localparam logic [BYTE_W-1:0]  SIG_M     = 8'h4D;
    localparam logic [31:0]        MIN_OFFSET = 32'd30;

    // Header byte positions
    localparam logic [4:0] POS_SIG0     = 5'd0;
    localparam logic [4:0] POS_SIG1     = 5'd1;
    localparam logic [4:0] POS_OFFSET   = 5'd10;
    localparam logic [4:0] POS_OFFSET_E = 5'd13;
    localparam logic [4:0] POS_WIDTH    = 5'd18;
    localparam logic [4:0] POS_WIDTH_E  = 5'd21;
    localparam logic [4:0] POS_HEIGHT   = 5'd22;
    localparam logic [4:0] POS_HEIGHT_E = 5'd25;
    localparam logic [4:0] POS_BPP      = 5'd28;
    localparam logic [4:0] POS_BPP_E    = 5'd29;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_SIG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_FMT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_SIZE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEYED_MODE = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PIXELS = 5'b00100,
        PH_PAD    = 5'b01000,
        PH_IDLE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic                keyed_mode;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [COLOR_W-1:0] pixel_color;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               visible;
        logic               row_end;
        logic               image_done;
    } res_t;

    function automatic logic size_bad(input logic [31:0] v);
        return (v == 32'd0) || v[31] || (v > 32'(MAX_DIM));
    endfunction

    function automatic logic [31:0] lane_or32(input logic [31:0] word,
                                              input logic [7:0]  b,
                                              input logic [1:0]  lane);
        return word | (32'(b) << {lane, 3'b000});
    endfunction

    function automatic logic [COLOR_W-1:0] pack565(input logic [23:0] bgr);
        return {bgr[23:19], bgr[15:10], bgr[7:3]};
    endfunction

    function automatic logic [COLOR_W-1:0] swap16(input logic [COLOR_W-1:0] c);
        return {c[7:0], c[15:8]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bmpd_byte_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP byte stream interface
// Valid/ready channel carrying one file byte and a start-of-file flag.
// ----------------------------------------------------------------------------
interface bmpd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [bmpd_pkg::BYTE_W-1:0]   data_byte;
    logic                          file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface
`default_nettype wire

// ----- rtl/bmpd_pix_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP pixel result interface
// Valid/ready channel carrying one decoded pixel or an error result.
// ----------------------------------------------------------------------------
interface bmpd_pix_if;
    logic                          valid;
    logic                          ready;
    logic [bmpd_pkg::KIND_W-1:0]   result_kind;
    logic [bmpd_pkg::COLOR_W-1:0]  pixel_color;
    logic [bmpd_pkg::COORD_W-1:0]  pixel_x;
    logic [bmpd_pkg::COORD_W-1:0]  pixel_y;
    logic                          visible;
    logic                          row_end;
    logic                          image_done;

    modport source (output valid, output result_kind, output pixel_color,
                    output pixel_x, output pixel_y, output visible,
                    output row_end, output image_done, input ready);
    modport sink   (input valid, input result_kind, input pixel_color,
                    input pixel_x, input pixel_y, input visible,
                    input row_end, input image_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/bmpd_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP decoder configuration interface
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bmpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmpd_pkg::CFG_IDX_W-1:0]  index;
    logic [bmpd_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/bmpd_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP decoder configuration registers
// Holds the image origin and the colour-key mode; writes are always taken.
// ----------------------------------------------------------------------------
module bmpd_cfg_regs
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    bmpd_cfg_if.sink            cfg,
    output bmpd_pkg::cfg_t      cfg_out
);

    bmpd_pkg::cfg_t cfg_reg;
    bmpd_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bmpd_pkg::REG_ORIGIN_X:   cfg_next.origin_x   = cfg.data;
                bmpd_pkg::REG_ORIGIN_Y:   cfg_next.origin_y   = cfg.data;
                bmpd_pkg::REG_KEYED_MODE: cfg_next.keyed_mode = cfg.data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bmpd_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP stream parser
// Tracks header fields, skips to pixel data, assembles and places pixels.
// ----------------------------------------------------------------------------
module bmpd_parser
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [bmpd_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        file_start,
    input  wire bmpd_pkg::cfg_t              cfg,
    output logic                             res_valid,
    output bmpd_pkg::res_t                   res
);

    bmpd_pkg::phase_t                phase_reg, phase_next, cur_phase;
    logic [31:0]                     pos_reg, pos_next, cur_pos;
    logic [31:0]                     offset_reg, offset_next, cur_offset;
    logic [31:0]                     width_reg, width_next, cur_width;
    logic [31:0]                     height_reg, height_next, cur_height;
    logic [15:0]                     bpp_reg, bpp_next, cur_bpp;
    logic [1:0]                      pbi_reg, pbi_next, cur_pbi;
    logic [23:0]                     partial_reg, partial_next, cur_partial;
    logic [bmpd_pkg::CNT_W-1:0]      col_reg, col_next, cur_col;
    logic [bmpd_pkg::CNT_W-1:0]      row_reg, row_next, cur_row;
    logic [1:0]                      pad_reg, pad_next, cur_pad;

    logic [4:0]                      p5;
    logic                            hdr_low;
    logic [1:0]                      lane;
    logic                            do_pix;
    logic [2:0]                      bpb;
    logic [1:0]                      last_idx;
    logic [23:0]                     acc;
    logic [bmpd_pkg::COLOR_W-1:0]    color;
    logic [bmpd_pkg::COORD_W-1:0]    y_off;
    logic [1:0]                      row_low;

    always_comb
    begin
        // A start-of-file byte sees the cleared file state.
        cur_phase   = file_start ? bmpd_pkg::PH_HEADER : phase_reg;
        cur_pos     = file_start ? '0 : pos_reg;
        cur_offset  = file_start ? '0 : offset_reg;
        cur_width   = file_start ? '0 : width_reg;
        cur_height  = file_start ? '0 : height_reg;
        cur_bpp     = file_start ? '0 : bpp_reg;
        cur_pbi     = file_start ? '0 : pbi_reg;
        cur_partial = file_start ? '0 : partial_reg;
        cur_col     = file_start ? '0 : col_reg;
        cur_row     = file_start ? '0 : row_reg;
        cur_pad     = file_start ? '0 : pad_reg;

        phase_next   = cur_phase;
        offset_next  = cur_offset;
        width_next   = cur_width;
        height_next  = cur_height;
        bpp_next     = cur_bpp;
        pbi_next     = cur_pbi;
        partial_next = cur_partial;
        col_next     = cur_col;
        row_next     = cur_row;
        pad_next     = cur_pad;
        pos_next     = (cur_pos != '1) ? cur_pos + 32'd1 : cur_pos;

        res_valid = 1'b0;
        res       = '0;

        p5      = cur_pos[4:0];
        hdr_low = (cur_pos[31:5] == '0);
        lane    = 2'(p5[1:0] - 2'd2);

        bpb      = bpp_reg[5:3];
        last_idx = 2'(bpb - 3'd1);
        acc      = (cur_pbi != 2'd3)
                   ? (cur_partial | (24'(data_byte) << {cur_pbi, 3'b000}))
                   : cur_partial;
        color    = (bpp_reg == 16'd16) ? acc[15:0] : bmpd_pkg::pack565(acc);
        y_off    = 12'(height_reg[bmpd_pkg::COORD_W-1:0] - 12'd1 - cur_row);
        row_low  = 2'(width_reg[1:0] * bpb[1:0]);

        do_pix = 1'b0;

        case (cur_phase)
            bmpd_pkg::PH_HEADER:
            begin
                if (hdr_low)
                begin
                    if (p5 == bmpd_pkg::POS_SIG0)
                    begin
                        partial_next = 24'(data_byte);
                    end
                    else if (p5 == bmpd_pkg::POS_SIG1)
                    begin
                        if ((cur_partial != 24'(bmpd_pkg::SIG_B)) ||
                            (data_byte != bmpd_pkg::SIG_M))
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = bmpd_pkg::KIND_BAD_SIG;
                            phase_next      = bmpd_pkg::PH_IDLE;
                        end
                        else
                        begin
                            partial_next = '0;
                        end
                    end
                    else if (p5 inside {[bmpd_pkg::POS_OFFSET:bmpd_pkg::POS_OFFSET_E]})
                    begin
                        offset_next = bmpd_pkg::lane_or32(cur_offset, data_byte, lane);
                    end
                    else if (p5 inside {[bmpd_pkg::POS_WIDTH:bmpd_pkg::POS_WIDTH_E]})
                    begin
                        width_next = bmpd_pkg::lane_or32(cur_width, data_byte, lane);
                    end
                    else if (p5 inside {[bmpd_pkg::POS_HEIGHT:bmpd_pkg::POS_HEIGHT_E]})
                    begin
                        height_next = bmpd_pkg::lane_or32(cur_height, data_byte, lane);
                    end
                    else if (p5 inside {bmpd_pkg::POS_BPP, bmpd_pkg::POS_BPP_E})
                    begin
                        bpp_next = cur_bpp | (p5[0] ? {data_byte, 8'h00}
                                                    : {8'h00, data_byte});
                        if (p5 == bmpd_pkg::POS_BPP_E)
                        begin
                            if (!(bpp_next inside {16'd16, 16'd24, 16'd32}) ||
                                (cur_offset < bmpd_pkg::MIN_OFFSET))
                            begin
                                res_valid       = 1'b1;
                                res.result_kind = bmpd_pkg::KIND_BAD_FMT;
                                phase_next      = bmpd_pkg::PH_IDLE;
                            end
                            else if (bmpd_pkg::size_bad(cur_width) ||
                                     bmpd_pkg::size_bad(cur_height))
                            begin
                                res_valid       = 1'b1;
                                res.result_kind = bmpd_pkg::KIND_BAD_SIZE;
                                phase_next      = bmpd_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = bmpd_pkg::PH_SKIP;
                            end
                        end
                    end
                end
            end
            bmpd_pkg::PH_SKIP:
            begin
                if (cur_pos == cur_offset)
                begin
                    phase_next = bmpd_pkg::PH_PIXELS;
                    do_pix     = 1'b1;
                end
            end
            bmpd_pkg::PH_PIXELS:
            begin
                do_pix = 1'b1;
            end
            bmpd_pkg::PH_PAD:
            begin
                pad_next = 2'(cur_pad - 2'd1);
                if (pad_next == 2'd0)
                begin
                    phase_next = bmpd_pkg::PH_PIXELS;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase

        if (do_pix)
        begin
            if (cur_pbi != last_idx)
            begin
                partial_next = acc;
                pbi_next     = 2'(cur_pbi + 2'd1);
            end
            else
            begin
                partial_next      = '0;
                pbi_next          = '0;
                res_valid         = 1'b1;
                res.result_kind   = bmpd_pkg::KIND_PIXEL;
                res.pixel_color   = cfg.keyed_mode ? color : bmpd_pkg::swap16(color);
                res.visible       = !(cfg.keyed_mode && (color == bmpd_pkg::KEY_COLOR));
                res.pixel_x       = 12'({1'b0, cfg.origin_x} + cur_col);
                res.pixel_y       = 12'({1'b0, cfg.origin_y} + y_off);
                if (({1'b0, cur_col} + 13'd1) >= width_reg[bmpd_pkg::CMP_W-1:0])
                begin
                    res.row_end = 1'b1;
                    col_next    = '0;
                    if (({1'b0, cur_row} + 13'd1) >= height_reg[bmpd_pkg::CMP_W-1:0])
                    begin
                        res.image_done = 1'b1;
                        phase_next     = bmpd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        row_next   = 12'(cur_row + 12'd1);
                        pad_next   = 2'(2'd0 - row_low);
                        phase_next = (pad_next != 2'd0) ? bmpd_pkg::PH_PAD
                                                        : bmpd_pkg::PH_PIXELS;
                    end
                end
                else
                begin
                    col_next = 12'(cur_col + 12'd1);
                end
            end
        end

        res_valid = res_valid && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bmpd_pkg::PH_HEADER;
            pos_reg     <= '0;
            offset_reg  <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            pbi_reg     <= '0;
            partial_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            offset_reg  <= offset_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bpp_reg     <= bpp_next;
            pbi_reg     <= pbi_next;
            partial_reg <= partial_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bmpd_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// BMP decoder result register
// Holds one result for the output channel; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module bmpd_out_reg
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           res_valid,
    input  wire bmpd_pkg::res_t res,
    output logic                take,
    bmpd_pix_if.source          pixels
);

    logic           valid_reg;
    logic           valid_next;
    bmpd_pkg::res_t res_reg;

    assign take       = !valid_reg || pixels.ready;
    assign valid_next = take ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign pixels.valid       = valid_reg;
    assign pixels.result_kind = res_reg.result_kind;
    assign pixels.pixel_color = res_reg.pixel_color;
    assign pixels.pixel_x     = res_reg.pixel_x;
    assign pixels.pixel_y     = res_reg.pixel_y;
    assign pixels.visible     = res_reg.visible;
    assign pixels.row_end     = res_reg.row_end;
    assign pixels.image_done  = res_reg.image_done;

endmodule
`default_nettype wire

// ----- rtl/bmp_stream_to_rgb565_pixels.sv -----
// Latency: a result is presented in the cycle after the transfer of the byte that caused it.
// Throughput: one byte per cycle. A byte is taken only when the result register is empty or
// hands its result on in that same cycle, so a result that the receiver does not take holds
// the input.
// Reset: asynchronous and active low; the parser returns to the header phase with all file
// state cleared, the result register is emptied and the configuration reads zero.
`default_nettype none
// ----------------------------------------------------------------------------
// BMP stream to RGB565 pixels
// Parses an uncompressed BMP byte stream and emits placed RGB565 pixels.
// ----------------------------------------------------------------------------
module bmp_stream_to_rgb565_pixels
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmpd_byte_if.sink   stream,
    bmpd_pix_if.source  pixels,
    bmpd_cfg_if.sink    cfg
);

    // Configuration: origin of the image on screen and the colour-key mode.
    // Writes are expected only while no file is being decoded.
    bmpd_pkg::cfg_t cfg_val;

    // A byte transfer happens when the result register can take whatever the
    // byte produces, so ready simply follows the state of that register.
    logic           take;
    logic           accept;
    logic           res_valid;
    bmpd_pkg::res_t res;

    assign stream.ready = take;
    assign accept       = stream.valid && take;

    bmpd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    // The parser holds all per-file state. Each transferred byte advances it by
    // one step and may yield one pixel or one error result.
    bmpd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (stream.data_byte),
        .file_start (stream.file_start),
        .cfg        (cfg_val),
        .res_valid  (res_valid),
        .res        (res)
    );

    // The result register parts the byte side from the pixel side.
    bmpd_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (take),
        .pixels    (pixels)
    );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP stream to RGB565 pixels testbench
// Feeds whole and broken BMP files through the byte channel under random
// idling and a long output stall, predicts every pixel and error result in a
// scoreboard and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;

    // Idling rate of each side, in percent of cycles.
    localparam int IDLE_PCT     = 8;
    // Length of the deliberate output stall, in cycles.
    localparam int HOLD_CYCLES  = 400;
    // Results appear in the cycle after the causing transfer; allow a little more.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 250000;
    // Random stimulus per batch, counted in file bytes (noise excluded).
    localparam int BATCH_BYTES  = 140;

    // The block has three registers; the fourth index is written once to show
    // that it changes nothing.
    localparam logic [bmpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [15:0] GOOD_SIG = {bmpd_pkg::SIG_M, bmpd_pkg::SIG_B};

    typedef struct packed {
        logic [bmpd_pkg::BYTE_W-1:0] data;
        logic                        start;
    } byte_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a byte-level decoder that mirrors the block's parser and
    // keeps the results it predicts until the block delivers them.
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        logic [bmpd_pkg::ORIGIN_W-1:0] org_x;
        logic [bmpd_pkg::ORIGIN_W-1:0] org_y;
        logic                          keyed;

        bmpd_pkg::phase_t              stage;
        logic [31:0]                   pos;
        logic [31:0]                   offs;
        logic [31:0]                   width;
        logic [31:0]                   height;
        logic [15:0]                   bpp;
        logic [1:0]                    lane;
        logic [23:0]                   gather;
        logic [bmpd_pkg::CNT_W-1:0]    col;
        logic [bmpd_pkg::CNT_W-1:0]    row;
        logic [1:0]                    pad;

        bmpd_pkg::res_t                expected_pixels[$];
        int                            errors;

        function new();
            org_x  = '0;
            org_y  = '0;
            keyed  = 1'b0;
            errors = 0;
            clear_file();
        endfunction

        function void clear_file();
            stage  = bmpd_pkg::PH_HEADER;
            pos    = '0;
            offs   = '0;
            width  = '0;
            height = '0;
            bpp    = '0;
            lane   = '0;
            gather = '0;
            col    = '0;
            row    = '0;
            pad    = '0;
        endfunction

        function void set_reg(input logic [bmpd_pkg::CFG_IDX_W-1:0] idx,
                              input logic [bmpd_pkg::CFG_DAT_W-1:0] d);
            case (idx)
                bmpd_pkg::REG_ORIGIN_X:   org_x = d;
                bmpd_pkg::REG_ORIGIN_Y:   org_y = d;
                bmpd_pkg::REG_KEYED_MODE: keyed = d[0];
                default:                  ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // An error result carries only its kind; the parser then waits for
        // the next start of file.
        function void push_error(input logic [bmpd_pkg::KIND_W-1:0] kind);
            bmpd_pkg::res_t r;
            r = '0;
            r.result_kind = kind;
            expected_pixels.push_back(r);
            stage = bmpd_pkg::PH_IDLE;
        endfunction

        function void pixel_byte(input logic [bmpd_pkg::BYTE_W-1:0] b);
            logic [1:0]                   last;
            logic [bmpd_pkg::COLOR_W-1:0] color;
            logic [31:0]                  row_bytes;
            bmpd_pkg::res_t               r;
            last = 2'((bpp >> 3) - 16'd1);
            if (lane < 2'd3)
                gather = gather | (24'(b) << (8 * lane));
            if (lane != last)
            begin
                lane = lane + 2'd1;
                return;
            end
            if (bpp == 16'd16)
                color = gather[15:0];
            else
                color = {gather[23:19], gather[15:10], gather[7:3]};
            lane   = '0;
            gather = '0;

            r = '0;
            r.result_kind = bmpd_pkg::KIND_PIXEL;
            r.pixel_color = keyed ? color : {color[7:0], color[15:8]};
            r.pixel_x     = bmpd_pkg::COORD_W'(32'(org_x) + 32'(col));
            r.pixel_y     = bmpd_pkg::COORD_W'(32'(org_y) + height - 32'd1 - 32'(row));
            r.visible     = !(keyed && color == bmpd_pkg::KEY_COLOR);

            if (32'(col) + 32'd1 >= width)
            begin
                row_bytes = width * 32'(bpp >> 3);
                r.row_end = 1'b1;
                col = '0;
                if (32'(row) + 32'd1 >= height)
                begin
                    r.image_done = 1'b1;
                    stage = bmpd_pkg::PH_IDLE;
                end
                else
                begin
                    row   = row + 1'b1;
                    pad   = 2'(32'd0 - row_bytes);
                    stage = (pad != 2'd0) ? bmpd_pkg::PH_PAD : bmpd_pkg::PH_PIXELS;
                end
            end
            else
            begin
                col = col + 1'b1;
            end
            expected_pixels.push_back(r);
        endfunction

        // Called for every byte transfer on the input channel.
        function void note_byte(input logic [bmpd_pkg::BYTE_W-1:0] b, input logic start);
            if (start)
                clear_file();
            case (stage)
                bmpd_pkg::PH_HEADER:
                begin
                    if (pos == 32'(bmpd_pkg::POS_SIG0))
                    begin
                        gather = 24'(b);
                    end
                    else if (pos == 32'(bmpd_pkg::POS_SIG1))
                    begin
                        if (gather != 24'(bmpd_pkg::SIG_B) || b != bmpd_pkg::SIG_M)
                            push_error(bmpd_pkg::KIND_BAD_SIG);
                        else
                            gather = '0;
                    end
                    else if (pos >= 32'(bmpd_pkg::POS_OFFSET) &&
                             pos <= 32'(bmpd_pkg::POS_OFFSET_E))
                    begin
                        offs = offs | (32'(b) << (8 * (pos - 32'(bmpd_pkg::POS_OFFSET))));
                    end
                    else if (pos >= 32'(bmpd_pkg::POS_WIDTH) &&
                             pos <= 32'(bmpd_pkg::POS_WIDTH_E))
                    begin
                        width = width | (32'(b) << (8 * (pos - 32'(bmpd_pkg::POS_WIDTH))));
                    end
                    else if (pos >= 32'(bmpd_pkg::POS_HEIGHT) &&
                             pos <= 32'(bmpd_pkg::POS_HEIGHT_E))
                    begin
                        height = height |
                                 (32'(b) << (8 * (pos - 32'(bmpd_pkg::POS_HEIGHT))));
                    end
                    else if (pos == 32'(bmpd_pkg::POS_BPP) ||
                             pos == 32'(bmpd_pkg::POS_BPP_E))
                    begin
                        bpp = bpp | (16'(b) << (8 * (pos - 32'(bmpd_pkg::POS_BPP))));
                        if (pos == 32'(bmpd_pkg::POS_BPP_E))
                        begin
                            // Format faults take precedence over size faults.
                            if ((bpp != 16'd16 && bpp != 16'd24 && bpp != 16'd32) ||
                                offs < bmpd_pkg::MIN_OFFSET)
                                push_error(bmpd_pkg::KIND_BAD_FMT);
                            else if (width == 0 || width[31] ||
                                     width > 32'(bmpd_pkg::MAX_DIM) ||
                                     height == 0 || height[31] ||
                                     height > 32'(bmpd_pkg::MAX_DIM))
                                push_error(bmpd_pkg::KIND_BAD_SIZE);
                            else
                                stage = bmpd_pkg::PH_SKIP;
                        end
                    end
                end
                bmpd_pkg::PH_SKIP:
                begin
                    if (pos == offs)
                    begin
                        stage = bmpd_pkg::PH_PIXELS;
                        pixel_byte(b);
                    end
                end
                bmpd_pkg::PH_PIXELS: pixel_byte(b);
                bmpd_pkg::PH_PAD:
                begin
                    pad = pad - 2'd1;
                    if (pad == 2'd0)
                        stage = bmpd_pkg::PH_PIXELS;
                end
                default: ;
            endcase
            if (pos != 32'hFFFF_FFFF)
                pos = pos + 32'd1;
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Called for every result transfer on the output channel.
        function void check_pixel(input bmpd_pkg::res_t got);
            bmpd_pkg::res_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("result with no expectation waiting: kind %0d x %0d y %0d",
                       got.result_kind, got.pixel_x, got.pixel_y);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            compare_field("pixel_color", 32'(want.pixel_color), 32'(got.pixel_color));
            compare_field("pixel_x",     32'(want.pixel_x),     32'(got.pixel_x));
            compare_field("pixel_y",     32'(want.pixel_y),     32'(got.pixel_y));
            compare_field("visible",     32'(want.visible),     32'(got.visible));
            compare_field("row_end",     32'(want.row_end),     32'(got.row_end));
            compare_field("image_done",  32'(want.image_done),  32'(got.image_done));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    bmpd_byte_if stream ();
    bmpd_pix_if  pixels ();
    bmpd_cfg_if  cfg ();

    bmp_stream_to_rgb565_pixels DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream.sink),
        .pixels (pixels.source),
        .cfg    (cfg.sink)
    );

    pixel_scoreboard sb;
    byte_item_t      stream_bytes[$];
    int              fed_bytes;
    // When set, neither side idles: this gives the long stretch at full rate.
    bit              calm;
    // Bumped by the main sequence to ask the receiver for one long stall.
    int              hold_ask;

    // ------------------------------------------------------------------------
    // Stimulus builders. They only fill stream_bytes; push_bytes sends it.
    // ------------------------------------------------------------------------

    // Builds one file: the 30-byte header with the given fields, and, where
    // the header is one the block accepts and the offset is modest, the gap
    // up to the pixel data, the pixel rows and their padding. The file can be
    // cut short, and it is followed by trailing bytes that the block ignores unless the file was cut short.
    task automatic add_file(input bit first_start, input logic [15:0] sig,
                            input logic [15:0] depth, input logic [31:0] offs,
                            input logic [31:0] w, input logic [31:0] h,
                            input int cut, input int tail);
        logic [bmpd_pkg::BYTE_W-1:0] body[$];
        logic [bmpd_pkg::BYTE_W-1:0] hdr[30];
        byte_item_t                  item;
        bit                          payload;
        bit                          key;
        int                          pad_len;
        for (int i = 0; i < 30; i++)
            hdr[i] = bmpd_pkg::BYTE_W'($urandom);
        hdr[0] = sig[7:0];
        hdr[1] = sig[15:8];
        for (int i = 0; i < 4; i++)
        begin
            hdr[10 + i] = offs[8*i +: 8];
            hdr[18 + i] = w[8*i +: 8];
            hdr[22 + i] = h[8*i +: 8];
        end
        hdr[28] = depth[7:0];
        hdr[29] = depth[15:8];
        for (int i = 0; i < 30; i++)
            body.push_back(hdr[i]);

        payload = sig == GOOD_SIG && (depth == 16 || depth == 24 || depth == 32) &&
                  offs >= bmpd_pkg::MIN_OFFSET && offs <= bmpd_pkg::MIN_OFFSET + 64 &&
                  w >= 1 && w <= bmpd_pkg::MAX_DIM && h >= 1 && h <= bmpd_pkg::MAX_DIM;
        if (payload)
        begin
            repeat (int'(offs - bmpd_pkg::MIN_OFFSET))
                body.push_back(bmpd_pkg::BYTE_W'($urandom));
            pad_len = int'((32'd0 - w * 32'(depth >> 3)) & 32'd3);
            for (int r = 0; r < int'(h); r++)
            begin
                for (int c = 0; c < int'(w); c++)
                begin
                    // About one pixel in eight is the magenta key colour.
                    key = ($urandom_range(7) == 0);
                    if (depth == 16)
                    begin
                        body.push_back(key ? 8'h1F : bmpd_pkg::BYTE_W'($urandom));
                        body.push_back(key ? 8'hF8 : bmpd_pkg::BYTE_W'($urandom));
                    end
                    else
                    begin
                        body.push_back(key ? 8'hF8 | 8'($urandom_range(7)) : 8'($urandom));
                        body.push_back(key ? 8'($urandom_range(3)) : 8'($urandom));
                        body.push_back(key ? 8'hF8 | 8'($urandom_range(7)) : 8'($urandom));
                        if (depth == 32)
                            body.push_back(bmpd_pkg::BYTE_W'($urandom));
                    end
                end
                repeat (pad_len)
                    body.push_back(bmpd_pkg::BYTE_W'($urandom));
            end
        end

        if (cut >= 0)
            while (body.size() > cut)
                void'(body.pop_back());
        fed_bytes += body.size();
        repeat (tail)
            body.push_back(bmpd_pkg::BYTE_W'($urandom));

        foreach (body[i])
        begin
            item.data  = body[i];
            item.start = (i == 0) ? first_start : 1'b0;
            stream_bytes.push_back(item);
        end
    endtask

    // A width or height that the block must reject.
    function automatic logic [31:0] bad_size();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'h8000_0000 | $urandom;
            2:       return 32'(bmpd_pkg::MAX_DIM) + 32'd1 + $urandom_range(4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_depth();
        case ($urandom_range(2))
            0:       return 16'd16;
            1:       return 16'd24;
            default: return 16'd32;
        endcase
    endfunction

    // Mostly small well-formed files with random content, the rest broken
    // files, header faults and stray bytes.
    task automatic add_random_files(input int budget);
        byte_item_t  item;
        logic [15:0] sig;
        int          pick;
        fed_bytes = 0;
        while (fed_bytes < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                // An eighth of these are cut short and restarted by the next file.
                add_file(1'b1, GOOD_SIG, pick_depth(),
                         bmpd_pkg::MIN_OFFSET + $urandom_range(5),
                         $urandom_range(1, 6), $urandom_range(1, 4),
                         (pick < 70) ? -1 : $urandom_range(2, 60), $urandom_range(3));
            end
            else if (pick < 92)
            begin
                case ($urandom_range(5))
                    0:
                    begin
                        sig = 16'($urandom);
                        if (sig == GOOD_SIG)
                            sig[0] = ~sig[0];
                        add_file(1'b1, sig, 16'd24, 32'd30, 2, 2, -1, $urandom_range(6));
                    end
                    1: add_file(1'b1, GOOD_SIG, 16'($urandom), 32'd30, 2, 2, -1,
                                $urandom_range(6));
                    2: add_file(1'b1, GOOD_SIG, pick_depth(), $urandom_range(29),
                                bad_size(), 2, -1, $urandom_range(6));
                    3: add_file(1'b1, GOOD_SIG, pick_depth(), 32'd30, bad_size(),
                                $urandom_range(1, 4), -1, $urandom_range(6));
                    4: add_file(1'b1, GOOD_SIG, pick_depth(), 32'd30,
                                $urandom_range(1, 4), bad_size(), -1, $urandom_range(6));
                    default:
                        // Pixel data far beyond the end of what is sent.
                        add_file(1'b1, GOOD_SIG, pick_depth(), $urandom | 32'h0001_0000,
                                 2, 2, -1, $urandom_range(10));
                endcase
            end
            else
            begin
                // Stray bytes, now and then with a start of file among them.
                repeat ($urandom_range(3, 12))
                begin
                    item.data  = bmpd_pkg::BYTE_W'($urandom);
                    item.start = ($urandom_range(9) == 0);
                    stream_bytes.push_back(item);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Channel drivers.
    // ------------------------------------------------------------------------

    // Sends everything in stream_bytes. An offered byte is held until its
    // transfer; idle cycles are only inserted between bytes. Each transfer is
    // passed to the scoreboard at the edge where it happens.
    task automatic push_bytes();
        int sent;
        bit waiting;
        sent    = 0;
        waiting = 1'b0;
        while (sent < stream_bytes.size())
        begin
            if (!waiting && !calm && $urandom_range(99) < IDLE_PCT)
            begin
                stream.valid <= 1'b0;
            end
            else
            begin
                stream.valid      <= 1'b1;
                stream.data_byte  <= stream_bytes[sent].data;
                stream.file_start <= stream_bytes[sent].start;
                waiting = 1'b1;
            end
            @(posedge clk);
            if (stream.valid && stream.ready)
            begin
                sb.note_byte(stream.data_byte, stream.file_start);
                sent++;
                waiting = 1'b0;
            end
        end
        stream.valid <= 1'b0;
        stream_bytes.delete();
    endtask

    // Waits for every predicted result and then for the block's latency, so
    // that a byte that causes no result has surely been absorbed too.
    task automatic wait_for_quiet();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes all three registers, and optionally the unused index. The
    // keyed-mode write carries random upper bits, which the block ignores.
    task automatic write_config(input logic [bmpd_pkg::CFG_DAT_W-1:0] ox,
                                input logic [bmpd_pkg::CFG_DAT_W-1:0] oy,
                                input logic keyed, input bit spare);
        logic [bmpd_pkg::CFG_IDX_W-1:0] idx_list[$];
        logic [bmpd_pkg::CFG_DAT_W-1:0] val_list[$];
        idx_list.push_back(bmpd_pkg::REG_ORIGIN_X);
        val_list.push_back(ox);
        idx_list.push_back(bmpd_pkg::REG_ORIGIN_Y);
        val_list.push_back(oy);
        idx_list.push_back(bmpd_pkg::REG_KEYED_MODE);
        val_list.push_back(bmpd_pkg::CFG_DAT_W'({$urandom_range(1023), keyed}));
        if (spare)
        begin
            idx_list.push_back(REG_SPARE);
            val_list.push_back(bmpd_pkg::CFG_DAT_W'($urandom));
        end
        foreach (idx_list[i])
        begin
            cfg.valid <= 1'b1;
            cfg.index <= idx_list[i];
            cfg.data  <= val_list[i];
            do
                @(posedge clk);
            while (!cfg.ready);
            sb.set_reg(idx_list[i], val_list[i]);
        end
        cfg.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: checks every result transfer and drives ready. It idles at
    // random unless calm is set, and on request holds ready low for a long
    // stretch so that the block backs up and stops taking bytes.
    // ------------------------------------------------------------------------
    initial
    begin
        bmpd_pkg::res_t got;
        int             hold_left;
        int             hold_seen;
        hold_left = 0;
        hold_seen = 0;
        pixels.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixels.valid && pixels.ready)
            begin
                got.result_kind = pixels.result_kind;
                got.pixel_color = pixels.pixel_color;
                got.pixel_x     = pixels.pixel_x;
                got.pixel_y     = pixels.pixel_y;
                got.visible     = pixels.visible;
                got.row_end     = pixels.row_end;
                got.image_done  = pixels.image_done;
                sb.check_pixel(got);
            end
            if (hold_seen != hold_ask)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixels.ready <= 1'b0;
            end
            else
            begin
                pixels.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $error("run exceeded %0d cycles with %0d results outstanding",
                       CYCLE_LIMIT, sb.pending());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        sb       = new();
        calm     = 1'b0;
        hold_ask = 0;
        rst_n             <= 1'b0;
        stream.valid      <= 1'b0;
        stream.data_byte  <= '0;
        stream.file_start <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= bmpd_pkg::REG_ORIGIN_X;
        cfg.data          <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files under the reset configuration. The very first file
        // has no start flag: the parser must take its first byte as byte 0.
        add_file(1'b0, GOOD_SIG, 16'd24, 32'd30, 3, 2, -1, 2);
        // Bad signature in the first byte, then in the second.
        add_file(1'b1, {bmpd_pkg::SIG_M, 8'h58}, 16'd24, 32'd30, 2, 2, -1, 3);
        add_file(1'b1, {8'h4E, bmpd_pkg::SIG_B}, 16'd24, 32'd30, 2, 2, -1, 3);
        // Unsupported depths, one only in its upper byte.
        add_file(1'b1, GOOD_SIG, 16'd8, 32'd30, 2, 2, -1, 2);
        add_file(1'b1, GOOD_SIG, 16'h0118, 32'd30, 2, 2, -1, 2);
        // Offset just below the header end, with a bad width as well: the
        // format fault must win.
        add_file(1'b1, GOOD_SIG, 16'd16, 32'd29, 32'd0, 2, -1, 2);
        // Size faults: zero width, negative height, width just above the limit.
        add_file(1'b1, GOOD_SIG, 16'd32, 32'd30, 32'd0, 2, -1, 2);
        add_file(1'b1, GOOD_SIG, 16'd32, 32'd30, 2, 32'hFFFF_FFFF, -1, 2);
        add_file(1'b1, GOOD_SIG, 16'd24, 32'd30, 32'(bmpd_pkg::MAX_DIM) + 1, 1, -1, 2);
        // Each depth, some with skipped bytes before the data, and paddings of 0, 1 and 2 bytes.
        add_file(1'b1, GOOD_SIG, 16'd16, 32'd37, 3, 2, -1, 4);
        add_file(1'b1, GOOD_SIG, 16'd32, 32'd30, 2, 3, -1, 0);
        add_file(1'b1, GOOD_SIG, 16'd24, 32'd31, 4, 1, -1, 1);
        add_file(1'b1, GOOD_SIG, 16'd24, 32'd30, 1, 3, -1, 1);
        add_file(1'b1, GOOD_SIG, 16'd24, 32'd30, 2, 2, -1, 1);
        // Restart in the middle of the pixel data and in the middle of the header.
        add_file(1'b1, GOOD_SIG, 16'd16, 32'd30, 4, 4, 40, 0);
        add_file(1'b1, GOOD_SIG, 16'd16, 32'd30, 4, 4, 15, 0);
        // Pixel data so far away that it is never reached.
        add_file(1'b1, GOOD_SIG, 16'd16, 32'hFFFF_FF00, 2, 2, -1, 20);
        push_bytes();
        wait_for_quiet();

        // Largest origins with keyed mode, one file of each depth. The unused
        // index is written too.
        write_config(11'h7FF, 11'h7FF, 1'b1, 1'b1);
        add_file(1'b1, GOOD_SIG, 16'd16, 32'd30, 4, 2, -1, 0);
        add_file(1'b1, GOOD_SIG, 16'd24, 32'd30, 3, 3, -1, 0);
        add_file(1'b1, GOOD_SIG, 16'd32, 32'd30, 2, 2, -1, 0);
        push_bytes();
        wait_for_quiet();

        // Random files while the receiver stalls for a long stretch at the
        // start: the block must fill up and refuse further bytes meanwhile.
        hold_ask++;
        add_random_files(BATCH_BYTES);
        push_bytes();
        wait_for_quiet();

        // Smallest origins, byte-swapped colours, no idling on either side.
        write_config(11'h000, 11'h000, 1'b0, 1'b0);
        calm = 1'b1;
        add_random_files(BATCH_BYTES);
        push_bytes();
        wait_for_quiet();
        calm = 1'b0;

        // Two random settings, one of each mode.
        write_config(bmpd_pkg::CFG_DAT_W'($urandom), bmpd_pkg::CFG_DAT_W'($urandom),
                     1'b1, 1'b0);
        add_random_files(BATCH_BYTES);
        push_bytes();
        wait_for_quiet();

        write_config(bmpd_pkg::CFG_DAT_W'($urandom), bmpd_pkg::CFG_DAT_W'($urandom),
                     1'b0, 1'b0);
        add_random_files(BATCH_BYTES);
        push_bytes();
        wait_for_quiet();

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
